### sv/ipt_pkg.sv
`default_nettype none

package ipt_pkg;

   // event kinds
   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // result status codes
   localparam logic [2:0] STAT_NEW     = 3'd0;
   localparam logic [2:0] STAT_RESTART = 3'd1;
   localparam logic [2:0] STAT_ENDED   = 3'd2;
   localparam logic [2:0] STAT_FULL    = 3'd3;
   localparam logic [2:0] STAT_MISSING = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] section_key;
      logic [47:0] timestamp;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [47:0] interval;
      logic [63:0] total_ticks;
      logic [31:0] call_count;
      logic [47:0] fastest;
      logic [47:0] slowest;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELECT,
      ST_READ,
      ST_SUB,
      ST_ADD,
      ST_BEGIN_WR,
      ST_END_WR
   } state_type;

endpackage

`default_nettype wire

### sv/interval_profile_table.sv
`default_nettype none

// Channel     | Ports                       | Transfer
// ------------+-----------------------------+------------------------------------------
// request     | start, busy, req_data       | edge with start high and busy low
// response    | rsp_valid, rsp_data         | edge ending the one cycle rsp_valid is high
//
// Clear/unknown: accept only; table full / key not found: accept, slot select.
// Begin: accept, select, stats read, write back; end: accept, select, read,
// subtract, add, write back, on the one shared 64-bit adder.
// Synchronous reset frees every slot and drops any event in flight; no clearing pass.
// The receiver cannot stall: each result shows for one cycle, and busy falls
// in that same cycle so the next event may be accepted alongside it.

module interval_profile_table #(
   parameter int ENTRIES    = 16,
   parameter int RANK_DEPTH = 2,
   parameter int KEY_BITS   = 16,
   parameter int TIME_BITS  = 48
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  ipt_pkg::req_type req_data,
   output logic             rsp_valid,
   output ipt_pkg::rsp_type rsp_data
);
   import ipt_pkg::*;

   localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef logic [RANK_DEPTH-1:0][TIME_BITS-1:0] rank_row_type;

   // sequencer
   state_type state_ff, state_in;

   // latched request
   logic [1:0]           kind_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [TIME_BITS-1:0] ts_ff;
   logic [ENTRIES-1:0]   hit_ff;

   // slot directory, flip-flops compared in parallel
   logic [ENTRIES-1:0]   used_ff;
   logic [KEY_BITS-1:0]  slot_key_ff [ENTRIES];

   // per-slot statistics memories
   logic [TIME_BITS-1:0] start_mem [ENTRIES];
   logic [63:0]          sum_mem   [ENTRIES];
   logic [31:0]          calls_mem [ENTRIES];
   rank_row_type         min_mem   [ENTRIES];
   rank_row_type         max_mem   [ENTRIES];

   logic [TIME_BITS-1:0] start_rd_ff;
   logic [63:0]          sum_rd_ff;
   logic [31:0]          calls_rd_ff;
   rank_row_type         min_rd_ff;
   rank_row_type         max_rd_ff;

   // working registers
   logic [SLOT_BITS-1:0] slot_ff;
   logic                 new_ff;
   logic [TIME_BITS-1:0] iv_ff;
   logic [63:0]          sum_new_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // combinational
   logic                 accept;
   logic [KEY_BITS-1:0]  key_in;
   logic [TIME_BITS-1:0] ts_in;
   logic [ENTRIES-1:0]   hit_in;
   logic [SLOT_BITS-1:0] sel_idx;
   logic                 found;
   logic [63:0]          alu_a, alu_b;
   logic                 alu_sub;
   logic [64:0]          alu_res;
   logic [31:0]          calls_new;
   logic [RANK_DEPTH-1:0] min_lt, max_gt;
   rank_row_type         min_new, max_new;
   logic                 clear_all, claim_slot, start_we, stats_we;
   logic [63:0]          sum_wr;
   logic [31:0]          calls_wr;
   rank_row_type         min_wr, max_wr;
   rsp_type              neutral;
   logic [63:0]          iv_ext, min_ext, max_ext, time_ones;
   logic [7:0]           slot_ext;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // narrow the key and timestamp to the configured widths
   assign key_in = KEY_BITS'(req_data.section_key);
   assign ts_in  = TIME_BITS'(req_data.timestamp);

   // begin hits a matching used slot or a free one; end hits a matching used slot
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_in[i] = used_ff[i] && (slot_key_ff[i] == key_in);
         if (req_data.kind == KIND_BEGIN && !used_ff[i]) begin
            hit_in[i] = 1'b1;
         end
      end
   end

   // lowest hit wins, as in an upward scan
   always_comb begin
      sel_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            sel_idx = SLOT_BITS'(i);
         end
      end
   end
   assign found = |hit_ff;

   // shared adder: interval subtract, then saturating total add
   always_comb begin
      if (state_ff == ST_SUB) begin
         alu_a   = 64'(ts_ff);
         alu_b   = 64'(start_rd_ff);
         alu_sub = 1'b1;
      end else begin
         alu_a   = sum_rd_ff;
         alu_b   = 64'(iv_ff);
         alu_sub = 1'b0;
      end
      alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 65'(alu_sub);
   end

   assign calls_new = (calls_rd_ff == '1) ? calls_rd_ff : calls_rd_ff + 32'd1;

   // rank insertion; ties land after the equal entry
   always_comb begin
      for (int p = 0; p < RANK_DEPTH; p++) begin
         min_lt[p] = iv_ff < min_rd_ff[p];
         max_gt[p] = iv_ff > max_rd_ff[p];
      end
      min_new[0] = min_lt[0] ? iv_ff : min_rd_ff[0];
      max_new[0] = max_gt[0] ? iv_ff : max_rd_ff[0];
      for (int q = 1; q < RANK_DEPTH; q++) begin
         if (!min_lt[q]) begin
            min_new[q] = min_rd_ff[q];
         end else if (min_lt[q-1]) begin
            min_new[q] = min_rd_ff[q-1];
         end else begin
            min_new[q] = iv_ff;
         end
         if (!max_gt[q]) begin
            max_new[q] = max_rd_ff[q];
         end else if (max_gt[q-1]) begin
            max_new[q] = max_rd_ff[q-1];
         end else begin
            max_new[q] = iv_ff;
         end
      end
   end

   assign time_ones = 64'({TIME_BITS{1'b1}});
   assign iv_ext    = 64'(iv_ff);
   assign slot_ext  = 8'(slot_ff);

   always_comb begin
      neutral             = '0;
      neutral.fastest     = time_ones[47:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.kind == KIND_BEGIN || req_data.kind == KIND_END)) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT:   state_in = found ? ST_READ : ST_IDLE;
         ST_READ:     state_in = (kind_ff == KIND_BEGIN) ? ST_BEGIN_WR : ST_SUB;
         ST_SUB:      state_in = ST_ADD;
         ST_ADD:      state_in = ST_END_WR;
         ST_BEGIN_WR: state_in = ST_IDLE;
         ST_END_WR:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and write controls
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = neutral;
      clear_all    = 1'b0;
      claim_slot   = 1'b0;
      start_we     = 1'b0;
      stats_we     = 1'b0;
      sum_wr       = sum_new_ff;
      calls_wr     = calls_new;
      min_wr       = min_new;
      max_wr       = max_new;
      min_ext      = 64'(min_rd_ff[0]);
      max_ext      = 64'(max_rd_ff[0]);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind) inside
                  KIND_BEGIN, KIND_END: ;
                  KIND_CLEAR: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STAT_NEW;
                     clear_all     = 1'b1;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STAT_MISSING;
                  end
               endcase
            end
         end
         ST_SELECT: begin
            if (!found) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = (kind_ff == KIND_BEGIN) ? STAT_FULL : STAT_MISSING;
            end
         end
         ST_BEGIN_WR: begin
            start_we     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in.slot  = slot_ext[3:0];
            if (new_ff) begin
               // fresh slot: wipe its statistics
               claim_slot    = 1'b1;
               stats_we      = 1'b1;
               sum_wr        = '0;
               calls_wr      = '0;
               for (int r = 0; r < RANK_DEPTH; r++) begin
                  min_wr[r] = '1;
                  max_wr[r] = '0;
               end
               rsp_in.status = STAT_NEW;
            end else begin
               rsp_in.status      = STAT_RESTART;
               rsp_in.total_ticks = sum_rd_ff;
               rsp_in.call_count  = calls_rd_ff;
               rsp_in.fastest     = min_ext[47:0];
               rsp_in.slowest     = max_ext[47:0];
            end
         end
         ST_END_WR: begin
            stats_we           = 1'b1;
            rsp_valid_in       = 1'b1;
            min_ext            = 64'(min_new[0]);
            max_ext            = 64'(max_new[0]);
            rsp_in.status      = STAT_ENDED;
            rsp_in.slot        = slot_ext[3:0];
            rsp_in.interval    = iv_ext[47:0];
            rsp_in.total_ticks = sum_new_ff;
            rsp_in.call_count  = calls_new;
            rsp_in.fastest     = min_ext[47:0];
            rsp_in.slowest     = max_ext[47:0];
         end
         ST_READ, ST_SUB, ST_ADD: ;
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clear_all) begin
            used_ff <= '0;
         end else if (claim_slot) begin
            used_ff[slot_ff] <= 1'b1;
         end
      end
   end

   // payload registers: hold the request, advance the working values
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         kind_ff <= req_data.kind;
         key_ff  <= key_in;
         ts_ff   <= ts_in;
         hit_ff  <= hit_in;
      end
      if (state_ff == ST_SELECT) begin
         slot_ff <= sel_idx;
         new_ff  <= !used_ff[sel_idx];
      end
      if (state_ff == ST_SUB) begin
         iv_ff <= alu_res[TIME_BITS-1:0];
      end
      if (state_ff == ST_ADD) begin
         sum_new_ff <= alu_res[64] ? '1 : alu_res[63:0];
      end
      if (claim_slot) begin
         slot_key_ff[slot_ff] <= key_ff;
      end
   end

   // statistics memories, one read and one write port each
   always_ff @(posedge clock) begin
      start_rd_ff <= start_mem[slot_ff];
      sum_rd_ff   <= sum_mem[slot_ff];
      calls_rd_ff <= calls_mem[slot_ff];
      min_rd_ff   <= min_mem[slot_ff];
      max_rd_ff   <= max_mem[slot_ff];
      if (start_we) begin
         start_mem[slot_ff] <= ts_ff;
      end
      if (stats_we) begin
         sum_mem[slot_ff]   <= sum_wr;
         calls_mem[slot_ff] <= calls_wr;
         min_mem[slot_ff]   <= min_wr;
         max_mem[slot_ff]   <= max_wr;
      end
   end

`ifndef ASSERT_OFF
   // a result never shows while an event is still in progress
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // a begin or end event always occupies the sequencer
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.kind == KIND_BEGIN || req_data.kind == KIND_END)) |=> busy)
      else $error("begin/end event did not start the sequencer");

   // an ended interval has been counted
   a_end_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STAT_ENDED) |-> (rsp_data.call_count != 32'd0))
      else $error("end result with zero call count");

   // a slot is only claimed when the sequencer chose a free one
   a_claim_free: assert property (@(posedge clock) disable iff (reset)
      claim_slot |-> !used_ff[slot_ff])
      else $error("claimed a slot already in use");
`endif

endmodule

`default_nettype wire

### tb/ipt_answer_check.sv
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow of the profiling table and compares
// every answer against the oldest outstanding prediction.
module ipt_answer_check #(
   parameter int SLOTS = 16,
   parameter int RANKS = 2
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   input  wire              busy,
   input  ipt_pkg::req_type req_data,
   input  wire              rsp_valid,
   input  ipt_pkg::rsp_type rsp_data,
   output int               fail_total,
   output int               pending,
   output int               answers_checked,
   output int               intervals_closed,
   output int               full_count,
   output int               missing_count
);
   import ipt_pkg::*;

   // shadow of the table
   logic        in_use     [SLOTS];
   logic [15:0] owner      [SLOTS];
   logic [47:0] began      [SLOTS];
   logic [63:0] total      [SLOTS];
   logic [31:0] count      [SLOTS];
   logic [47:0] fast_rank  [SLOTS][RANKS];
   logic [47:0] slow_rank  [SLOTS][RANKS];

   rsp_type expected_answers [$];
   rsp_type want;
   int      mismatches;
   int      checked;
   int      closed;
   int      fulls;
   int      missings;

   function automatic rsp_type profile_event(input req_type ev);
      rsp_type     ans;
      int          pick;
      logic [47:0] span;
      logic [64:0] wide;
      bit          placed_fast;
      bit          placed_slow;
      ans = '0;
      ans.fastest = '1;
      ans.status = STAT_MISSING;
      pick = -1;
      placed_fast = 1'b0;
      placed_slow = 1'b0;
      case (ev.kind)
         KIND_BEGIN: begin
            // first slot that either holds the key or is free wins
            for (int s = 0; s < SLOTS; s++)
               if (pick < 0 && (!in_use[s] || owner[s] == ev.section_key))
                  pick = s;
            if (pick < 0) begin
               ans.status = STAT_FULL;
            end else begin
               if (in_use[pick]) begin
                  ans.status = STAT_RESTART;
               end else begin
                  ans.status = STAT_NEW;
                  in_use[pick] = 1'b1;
                  owner[pick] = ev.section_key;
                  total[pick] = '0;
                  count[pick] = '0;
                  for (int r = 0; r < RANKS; r++) begin
                     fast_rank[pick][r] = '1;
                     slow_rank[pick][r] = '0;
                  end
               end
               began[pick] = ev.timestamp;
            end
         end
         KIND_END: begin
            for (int s = 0; s < SLOTS; s++)
               if (pick < 0 && in_use[s] && owner[s] == ev.section_key)
                  pick = s;
            if (pick >= 0) begin
               span = ev.timestamp - began[pick];
               wide = {1'b0, total[pick]} + {17'd0, span};
               total[pick] = wide[64] ? '1 : wide[63:0];
               if (count[pick] != '1)
                  count[pick] = count[pick] + 32'd1;
               // ties go behind the equal entry, hence strict compares
               for (int p = 0; p < RANKS; p++)
                  if (!placed_fast && span < fast_rank[pick][p]) begin
                     for (int q = RANKS - 1; q > p; q--)
                        fast_rank[pick][q] = fast_rank[pick][q - 1];
                     fast_rank[pick][p] = span;
                     placed_fast = 1'b1;
                  end
               for (int p = 0; p < RANKS; p++)
                  if (!placed_slow && span > slow_rank[pick][p]) begin
                     for (int q = RANKS - 1; q > p; q--)
                        slow_rank[pick][q] = slow_rank[pick][q - 1];
                     slow_rank[pick][p] = span;
                     placed_slow = 1'b1;
                  end
               ans.status = STAT_ENDED;
               ans.interval = span;
            end
         end
         KIND_CLEAR: begin
            for (int s = 0; s < SLOTS; s++)
               in_use[s] = 1'b0;
            ans.status = STAT_NEW;
         end
         default: begin
         end
      endcase
      if (pick >= 0) begin
         ans.slot = 4'(pick);
         ans.total_ticks = total[pick];
         ans.call_count = count[pick];
         ans.fastest = fast_rank[pick][0];
         ans.slowest = slow_rank[pick][0];
      end
      return ans;
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, got_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++)
            in_use[s] = 1'b0;
         expected_answers.delete();
      end else begin
         // retire before accepting: busy falls in the answer cycle
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               $error("answer with no event outstanding: status %0d", rsp_data.status);
               mismatches++;
            end else begin
               want = expected_answers.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("slot", 64'(want.slot), 64'(rsp_data.slot));
               check_field("interval", 64'(want.interval), 64'(rsp_data.interval));
               check_field("total_ticks", want.total_ticks, rsp_data.total_ticks);
               check_field("call_count", 64'(want.call_count), 64'(rsp_data.call_count));
               check_field("fastest", 64'(want.fastest), 64'(rsp_data.fastest));
               check_field("slowest", 64'(want.slowest), 64'(rsp_data.slowest));
               checked++;
               if (want.status == STAT_ENDED)
                  closed++;
               if (want.status == STAT_FULL)
                  fulls++;
               if (want.status == STAT_MISSING)
                  missings++;
            end
         end
         if (start && !busy)
            expected_answers.insert(expected_answers.size(), profile_event(req_data));
      end
      fail_total       <= mismatches;
      pending          <= expected_answers.size();
      answers_checked  <= checked;
      intervals_closed <= closed;
      full_count       <= fulls;
      missing_count    <= missings;
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import ipt_pkg::*;

   // kind 3 has no name in the package; the block must treat it as a lookup miss
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;
   localparam int RANDOM_EVENTS = 1525;
   localparam int POOL_KEYS     = 24;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_valid;
   req_type req_data;
   rsp_type rsp_data;

   int fail_total;
   int pending;
   int answers_checked;
   int intervals_closed;
   int full_count;
   int missing_count;

   int begins_sent;
   int ends_sent;
   int clears_sent;
   int others_sent;

   // working set of section keys: more keys than slots so the table can fill
   logic [15:0] key_pool   [POOL_KEYS];
   logic [47:0] pool_began [POOL_KEYS];
   logic        pool_live  [POOL_KEYS];
   logic [47:0] tick_now;

   interval_profile_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   ipt_answer_check answer_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .fail_total       (fail_total),
      .pending          (pending),
      .answers_checked  (answers_checked),
      .intervals_closed (intervals_closed),
      .full_count       (full_count),
      .missing_count    (missing_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs or drops an answer
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Present one event and hold it until the edge that takes the transfer.
   // start is left high on return so back-to-back events need no extra step.
   task automatic send_event(input logic [1:0] kind, input logic [15:0] key,
                             input logic [47:0] stamp);
      req_type ev;
      ev.kind = kind;
      ev.section_key = key;
      ev.timestamp = stamp;
      req_data <= ev;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      case (kind)
         KIND_BEGIN: begins_sent++;
         KIND_END:   ends_sent++;
         KIND_CLEAR: clears_sent++;
         default:    others_sent++;
      endcase
   endtask

   // Drop start now and then, so that gaps land on every stage of the lookup
   // and write-back.
   task automatic pause(input bit allowed);
      if (allowed && $urandom_range(99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Draw fresh keys; used after every clear so each table life sees new ids.
   task automatic refresh_pool;
      for (int p = 0; p < POOL_KEYS; p++) begin
         key_pool[p] = 16'($urandom);
         pool_live[p] = 1'b0;
      end
   endtask

   initial begin
      logic [15:0] key;
      logic [47:0] stamp;
      int          roll;
      int          p;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      begins_sent = 0;
      ends_sent = 0;
      clears_sent = 0;
      others_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // lookup miss on an empty table, then the unused kind
      pause(1'b1);
      send_event(KIND_END, 16'hFFFF, 48'h0);
      pause(1'b1);
      send_event(KIND_UNKNOWN, 16'h0000, '1);

      // fill all sixteen slots; slot 0 starts just below the counter wrap,
      // slot 1 at time zero with the all-ones key
      for (int i = 0; i < 16; i++) begin
         if (i == 0) begin
            key = 16'h0000;
            stamp = 48'hFFFF_FFFF_FFF0;
         end else if (i == 1) begin
            key = 16'hFFFF;
            stamp = 48'h0;
         end else begin
            key = {4'(i), 8'h00, 4'(i)};
            stamp = 48'(i * 1000);
         end
         pause(1'b1);
         send_event(KIND_BEGIN, key, stamp);
      end

      // new key with no free slot left
      pause(1'b1);
      send_event(KIND_BEGIN, 16'h1234, 48'h5);
      // counter wraps between begin and end of slot 0
      pause(1'b1);
      send_event(KIND_END, 16'h0000, 48'h10);
      // largest possible interval
      pause(1'b1);
      send_event(KIND_END, 16'hFFFF, '1);
      // zero-length interval
      pause(1'b1);
      send_event(KIND_END, 16'h2002, 48'd2000);
      // restart slot 0, then close it with the same interval as before (a tie)
      pause(1'b1);
      send_event(KIND_BEGIN, 16'h0000, 48'd100);
      pause(1'b1);
      send_event(KIND_END, 16'h0000, 48'd132);
      pause(1'b1);
      send_event(KIND_CLEAR, 16'hA5A5, 48'h0);

      // ---- random part ----
      // Mostly begin/end pairs over the key pool with a slowly advancing
      // tick count; the rest is stray ends, stray begins, unknown kinds and
      // the odd clear.
      refresh_pool();
      tick_now = {16'($urandom), $urandom};
      for (int n = 0; n < RANDOM_EVENTS; n++) begin
         // hold start high throughout one long stretch in the middle
         pause(n < 600 || n >= 900);
         roll = $urandom_range(999);
         p = $urandom_range(POOL_KEYS - 1);
         if ($urandom_range(49) == 0)
            tick_now = {16'($urandom), $urandom};
         else
            tick_now = tick_now + 48'($urandom_range(2000));

         if (roll < 440) begin
            send_event(KIND_BEGIN, key_pool[p], tick_now);
            pool_began[p] = tick_now;
            pool_live[p] = 1'b1;
         end else if (roll < 880) begin
            stamp = tick_now;
            // short, repeated intervals to provoke ties in the rank lists
            if (pool_live[p] && $urandom_range(4) == 0)
               stamp = pool_began[p] + 48'($urandom_range(3) * 16);
            send_event(KIND_END, key_pool[p], stamp);
         end else if (roll < 930) begin
            send_event(KIND_END, 16'($urandom), {16'($urandom), $urandom});
         end else if (roll < 965) begin
            send_event(KIND_BEGIN, 16'($urandom), {16'($urandom), $urandom});
         end else if (roll < 988) begin
            send_event(KIND_UNKNOWN, 16'($urandom), {16'($urandom), $urandom});
         end else begin
            send_event(KIND_CLEAR, 16'($urandom), tick_now);
            refresh_pool();
         end
      end

      // drain: let the last transfer register, then wait for every answer
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d begin, %0d end, %0d clear and %0d unknown-kind events.",
               begins_sent, ends_sent, clears_sent, others_sent);
      $display("Checked %0d answers: %0d closed intervals, %0d table full, %0d misses.",
               answers_checked, intervals_closed, full_count, missing_count);
      if (fail_total == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
